### hdl/mbrp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the modbus rtu request parser
// no dependencies; every other file but mbrp_if imports this package

package mbrp_pkg;

    localparam int DATA_BYTES = 64;                 // data store depth, 8 to 64
    localparam int IDX_W      = $clog2(DATA_BYTES); // store address width
    localparam int CNT_W      = IDX_W + 1;          // fill count, holds DATA_BYTES itself
    localparam int EXP_W      = 9;                  // expected length, up to 255 + 5
    localparam int BYTE_INDEX_W = 6;

    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_FIXED_LO   = 8'd1;
    localparam logic [7:0] FUNC_FIXED_HI   = 8'd6;
    localparam logic [7:0] FUNC_WRITE_MULT = 8'h10;
    localparam logic [7:0] LEN_FIXED       = 8'd4;
    localparam logic [7:0] LEN_BASE        = 8'd5;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_CRC  = 2'd1,
        KIND_OVF  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CMD_STORE   = 2'd0,
        CMD_RUN     = 2'd1,
        CMD_ERR_CRC = 2'd2,
        CMD_ERR_OVF = 2'd3
    } t_cmd_op;

    // one command from the front end to the back end
    typedef struct packed {
        t_cmd_op          op;
        logic [7:0]       function_code;
        logic [CNT_W-1:0] arg;    // store address or run length
        logic [7:0]       value;
    } t_cmd;

    // queue handshake toward either side
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

### hdl/mbrp_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for received bytes and parser results
// no dependencies

interface mbrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       sof;

    modport source (output valid, output rx_byte, output sof, input ready);
    modport sink   (input valid, input rx_byte, input sof, output ready);
endinterface

interface mbrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] function_code;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
    logic       last_of_run;

    modport source (output valid, output result_kind, output function_code,
                    output byte_index, output byte_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input result_kind, input function_code,
                    input byte_index, input byte_value, input last_of_run,
                    output ready);
endinterface

### hdl/mbrp_front.sv
`timescale 1ns / 1ps
// front end: frame state machine, crc-16 and byte classification
// depends on mbrp_pkg and mbrp_in_if; issues commands into the queue

module mbrp_front
    import mbrp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_slave_address,
    mbrp_in_if.sink       i_rx,
    input  logic          i_full,
    output t_cmd_req      o_push
);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_FUNC = 5'b00010,
        PH_DATA = 5'b00100,
        PH_CRCL = 5'b01000,
        PH_CRCH = 5'b10000
    } t_phase;

    t_phase           r_phase,    n_phase;
    logic [7:0]       r_func,     n_func;
    logic [EXP_W-1:0] r_expected, n_expected;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [15:0]      r_crc,      n_crc;
    logic [7:0]       r_crc_low,  n_crc_low;

    t_phase           s_phase;
    logic [7:0]       s_func;
    logic [EXP_W-1:0] s_expected;
    logic [CNT_W-1:0] s_count;
    logic [15:0]      s_crc;
    logic [7:0]       s_crc_low;
    logic             accept;
    logic [7:0]       b;
    logic [CNT_W-1:0] count_inc;
    logic [EXP_W-1:0] exp_upd;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign i_rx.ready = !i_full;
    assign accept     = i_rx.valid && !i_full;
    assign b          = i_rx.rx_byte;

    // frame start returns to idle before the byte is looked at
    always_comb begin
        if (i_rx.sof) begin
            s_phase    = PH_IDLE;
            s_func     = '0;
            s_expected = '0;
            s_count    = '0;
            s_crc      = '0;
            s_crc_low  = '0;
        end else begin
            s_phase    = r_phase;
            s_func     = r_func;
            s_expected = r_expected;
            s_count    = r_count;
            s_crc      = r_crc;
            s_crc_low  = r_crc_low;
        end
    end

    assign count_inc = s_count + CNT_W'(1);

    always_comb begin
        n_phase    = s_phase;
        n_func     = s_func;
        n_expected = s_expected;
        n_count    = s_count;
        n_crc      = s_crc;
        n_crc_low  = s_crc_low;
        exp_upd    = s_expected;
        o_push.valid             = 1'b0;
        o_push.cmd.op            = CMD_STORE;
        o_push.cmd.function_code = s_func;
        o_push.cmd.arg           = s_count;
        o_push.cmd.value         = b;
        unique case (s_phase)
            PH_IDLE: begin
                if (b == i_slave_address) begin
                    n_crc   = crc_feed(CRC_INIT, b);
                    n_phase = PH_FUNC;
                end
            end
            PH_FUNC: begin
                n_func  = b;
                n_crc   = crc_feed(s_crc, b);
                n_count = '0;
                n_phase = PH_DATA;
                if (b >= FUNC_FIXED_LO && b <= FUNC_FIXED_HI) begin
                    n_expected = EXP_W'(LEN_FIXED);
                end else if (b == FUNC_WRITE_MULT) begin
                    n_expected = EXP_W'(LEN_BASE);
                end else begin
                    n_expected = '0;
                end
            end
            PH_DATA: begin
                if (s_count >= CNT_W'(DATA_BYTES)) begin
                    // store full: drop the byte and report
                    o_push.valid   = 1'b1;
                    o_push.cmd.op  = CMD_ERR_OVF;
                    n_phase    = PH_IDLE;
                    n_func     = '0;
                    n_expected = '0;
                    n_count    = '0;
                    n_crc      = '0;
                    n_crc_low  = '0;
                end else begin
                    o_push.valid = 1'b1;
                    n_count = count_inc;
                    n_crc   = crc_feed(s_crc, b);
                    // fifth byte of a write-multiple request is its byte count
                    if (s_func == FUNC_WRITE_MULT && count_inc == CNT_W'(LEN_BASE)) begin
                        exp_upd = EXP_W'(b) + EXP_W'(LEN_BASE);
                    end
                    n_expected = exp_upd;
                    if (EXP_W'(count_inc) == exp_upd) begin
                        n_phase = PH_CRCL;
                    end
                end
            end
            PH_CRCL: begin
                n_crc_low = b;
                n_phase   = PH_CRCH;
            end
            PH_CRCH: begin
                o_push.valid  = 1'b1;
                o_push.cmd.op = (s_crc == {b, s_crc_low}) ? CMD_RUN : CMD_ERR_CRC;
                n_phase    = PH_IDLE;
                n_func     = '0;
                n_expected = '0;
                n_count    = '0;
                n_crc      = '0;
                n_crc_low  = '0;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (!accept) begin
            o_push.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_func     <= '0;
            r_expected <= '0;
            r_count    <= '0;
            r_crc      <= '0;
            r_crc_low  <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_func     <= n_func;
            r_expected <= n_expected;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_crc_low  <= n_crc_low;
        end
    end

endmodule

### hdl/mbrp_cmd_fifo.sv
`timescale 1ns / 1ps
// short command queue between the front end and the back end
// depends on mbrp_pkg

module mbrp_cmd_fifo
    import mbrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd_req i_push,
    output logic     o_full,
    output t_cmd_req o_head,
    input  logic     i_pop
);

    t_cmd                 r_slot [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_PTR_W:0]   r_fill,   n_fill;
    logic                 do_push;
    logic                 do_pop;

    assign o_full      = (r_fill == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_head.valid = (r_fill != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + CMD_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + CMD_PTR_W'(1) : r_rd_ptr;
        n_fill   = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + (CMD_PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - (CMD_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

### hdl/mbrp_back.sv
`timescale 1ns / 1ps
// back end: data store, result sequencing and output register
// depends on mbrp_pkg and mbrp_out_if; drains the command queue

module mbrp_back
    import mbrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_req  i_head,
    output logic      o_pop,
    mbrp_out_if.source o_res
);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_RD   = 3'b010,
        BK_OUT  = 3'b100
    } t_bk_state;

    t_bk_state        r_state, n_state;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [CNT_W-1:0] r_len,   n_len;
    logic [7:0]       r_func,  n_func;

    logic [7:0]       r_mem [DATA_BYTES];
    logic [7:0]       r_rd_data;

    logic             r_out_valid, n_out_valid;
    t_kind            r_kind,  n_kind;
    logic [7:0]       r_ofunc, n_ofunc;
    logic [BYTE_INDEX_W-1:0] r_oidx, n_oidx;
    logic [7:0]       r_oval,  n_oval;
    logic             r_olast, n_olast;

    logic             slot_free;
    logic             mem_we;
    logic             run_last;

    assign slot_free = !r_out_valid || o_res.ready;
    assign run_last  = ({1'b0, r_idx} + CNT_W'(1)) == r_len;

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_kind;
    assign o_res.function_code = r_ofunc;
    assign o_res.byte_index    = r_oidx;
    assign o_res.byte_value    = r_oval;
    assign o_res.last_of_run   = r_olast;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_func      = r_func;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_ofunc     = r_ofunc;
        n_oidx      = r_oidx;
        n_oval      = r_oval;
        n_olast     = r_olast;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd.op)
                        CMD_STORE: begin
                            mem_we = 1'b1;
                            o_pop  = 1'b1;
                        end
                        CMD_RUN: begin
                            o_pop   = 1'b1;
                            n_idx   = '0;
                            n_len   = i_head.cmd.arg;
                            n_func  = i_head.cmd.function_code;
                            n_state = BK_RD;
                        end
                        CMD_ERR_CRC, CMD_ERR_OVF: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_kind      = (i_head.cmd.op == CMD_ERR_CRC) ? KIND_CRC
                                                                              : KIND_OVF;
                                n_ofunc     = i_head.cmd.function_code;
                                n_oidx      = '0;
                                n_oval      = '0;
                                n_olast     = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_RD: begin
                // read data for r_idx is registered into r_rd_data for use in BK_OUT
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DATA;
                    n_ofunc     = r_func;
                    n_oidx      = BYTE_INDEX_W'(r_idx);
                    n_oval      = r_rd_data;
                    n_olast     = run_last;
                    if (run_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = BK_RD;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_len   <= n_len;
        r_func  <= n_func;
        r_kind  <= n_kind;
        r_ofunc <= n_ofunc;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.cmd.arg[IDX_W-1:0]] <= i_head.cmd.value;
        end
        r_rd_data <= r_mem[r_idx];
    end

endmodule

### hdl/modbus_rtu_request_parser.sv
`timescale 1ns / 1ps
// top level of the modbus rtu request parser: config register and wiring
// depends on mbrp_pkg, mbrp_if, mbrp_front, mbrp_cmd_fifo and mbrp_back
//
// usage: i_rx carries one received byte per item, sof marking the first
//   byte of a frame; o_res carries result items: data bytes of a good
//   request, or a single crc mismatch or store overflow error.
//   i_cfg_wr_en / i_cfg_wr_data write the own station address (reset 1).
// timing: the front end takes one byte per cycle while its 4-entry command
//   queue has room; crc-16 is folded in within that same cycle.
//   the back end writes each stored data byte and loads each error into
//   the output register as it pops them; each result of a data run takes
//   a store read (BK_RD), then the output register (BK_OUT), and no
//   command is popped during a run. a data result thus passes the queue,
//   BK_RD and BK_OUT; an error result the queue and the output register.
// reset: synchronous, active low: parser back to idle, queue and output
//   empty; store contents are not cleared, every byte reported was written
// stalls: the output register holds while o_res.ready is low, the back end
//   then stops, the queue fills and i_rx.ready drops.

module modbus_rtu_request_parser
    import mbrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mbrp_in_if.sink    i_rx,
    mbrp_out_if.source o_res
);

    logic [7:0] r_slave_address;
    t_cmd_req   push;
    t_cmd_req   head;
    logic       full;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 8'd1;
        end else if (i_cfg_wr_en) begin
            r_slave_address <= i_cfg_wr_data;
        end
    end

    mbrp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_address (r_slave_address),
        .i_rx            (i_rx),
        .i_full          (full),
        .o_push          (push)
    );

    mbrp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    mbrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for modbus_rtu_request_parser: request frames with random content
// are checked against a byte-level model of the parser; needs mbrp_pkg, mbrp_if and the rtl

module testbench;
    import mbrp_pkg::*;

    localparam int QUIET_LIMIT   = 4000;   // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 74;
    localparam int PRINT_LIMIT   = 30;
    localparam int MAX_COUNT     = DATA_BYTES - int'(LEN_BASE);  // largest byte count that fits

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_FUNC,
        PARSE_DATA,
        PARSE_CRC_LO,
        PARSE_CRC_HI
    } parse_phase_e;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] function_code;
        logic [5:0] byte_index;
        logic [7:0] byte_value;
        logic       last_of_run;
    } parser_result_t;

    class request_scoreboard;
        logic [7:0]     station_address;
        parse_phase_e   phase;
        logic [7:0]     func_code;
        logic [8:0]     frame_length;
        logic [6:0]     fill_count;
        logic [15:0]    crc_acc;
        logic [7:0]     crc_lo;
        logic [7:0]     data_bytes [DATA_BYTES];
        parser_result_t pending_results[$];
        int             mismatches;

        function new();
            station_address = 8'd1;
            mismatches      = 0;
            clear_frame();
        endfunction

        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void clear_frame();
            phase        = PARSE_IDLE;
            func_code    = '0;
            frame_length = '0;
            fill_count   = '0;
            crc_acc      = '0;
            crc_lo       = '0;
        endfunction

        function void push_error(t_kind kind);
            parser_result_t r;
            r.kind          = kind;
            r.function_code = func_code;
            r.byte_index    = '0;
            r.byte_value    = '0;
            r.last_of_run   = 1'b1;
            pending_results.push_back(r);
        endfunction

        // one accepted input item
        function void take_rx_byte(logic [7:0] b, logic sof);
            parser_result_t r;
            int i;
            if (sof) clear_frame();
            case (phase)
                PARSE_IDLE: begin
                    if (b == station_address) begin
                        crc_acc = crc_step(CRC_INIT, b);
                        phase   = PARSE_FUNC;
                    end
                end
                PARSE_FUNC: begin
                    func_code = b;
                    crc_acc   = crc_step(crc_acc, b);
                    if (b >= FUNC_FIXED_LO && b <= FUNC_FIXED_HI) begin
                        frame_length = 9'(LEN_FIXED);
                    end else if (b == FUNC_WRITE_MULT) begin
                        frame_length = 9'(LEN_BASE);
                    end else begin
                        frame_length = '0;
                    end
                    fill_count = '0;
                    phase      = PARSE_DATA;
                end
                PARSE_DATA: begin
                    if (fill_count >= DATA_BYTES) begin
                        // store full: byte dropped
                        push_error(KIND_OVF);
                        clear_frame();
                    end else begin
                        data_bytes[fill_count[IDX_W-1:0]] = b;
                        fill_count = fill_count + 7'd1;
                        crc_acc    = crc_step(crc_acc, b);
                        // byte count of a write-multiple sets the real length
                        if (func_code == FUNC_WRITE_MULT && fill_count == 7'(LEN_BASE))
                            frame_length = 9'(data_bytes[IDX_W'(LEN_BASE - 8'd1)])
                                           + 9'(LEN_BASE);
                        if (9'(fill_count) == frame_length) phase = PARSE_CRC_LO;
                    end
                end
                PARSE_CRC_LO: begin
                    crc_lo = b;
                    phase  = PARSE_CRC_HI;
                end
                PARSE_CRC_HI: begin
                    if (crc_acc == {b, crc_lo}) begin
                        for (i = 0; i < fill_count; i++) begin
                            r.kind          = KIND_DATA;
                            r.function_code = func_code;
                            r.byte_index    = 6'(i);
                            r.byte_value    = data_bytes[IDX_W'(i)];
                            r.last_of_run   = (i == fill_count - 1);
                            pending_results.push_back(r);
                        end
                    end else begin
                        push_error(KIND_CRC);
                    end
                    clear_frame();
                end
                default: phase = PARSE_IDLE;
            endcase
        endfunction

        function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
            if (got === want) return 1'b0;
            if (mismatches < PRINT_LIMIT)
                $display("t=%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] fc, logic [5:0] idx,
                                   logic [7:0] val, logic last);
            parser_result_t want;
            bit bad;
            if (pending_results.size() == 0) begin
                if (mismatches < PRINT_LIMIT)
                    $display("t=%0t: no result expected, got kind %0h function %0h index %0h %s",
                             $time, kind, fc, idx, $sformatf("value %0h last %0b", val, last));
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            bad  = field_differs("result_kind", 8'(want.kind), 8'(kind));
            bad  = bad | field_differs("function_code", want.function_code, fc);
            bad  = bad | field_differs("byte_index", 8'(want.byte_index), 8'(idx));
            bad  = bad | field_differs("byte_value", want.byte_value, val);
            bad  = bad | field_differs("last_of_run", 8'(want.last_of_run), 8'(last));
            if (bad) mismatches++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_wr_en;
    logic [7:0] cfg_wr_data;

    mbrp_in_if  rx_ch();
    mbrp_out_if res_ch();

    request_scoreboard sb;
    logic [7:0] frame_buf[$];
    bit  idling_on;
    bit  ignored_traffic;
    int  counted_items;

    modbus_rtu_request_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_rx         (rx_ch.sink),
        .o_res        (res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: ready in random bursts, stalls only while idling is on
    initial begin
        res_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (idling_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result(res_ch.result_kind, res_ch.function_code, res_ch.byte_index,
                            res_ch.byte_value, res_ch.last_of_run);
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    // valid stays high from one item to the next unless a gap is taken
    task automatic send_item(input logic [7:0] b, input logic sof);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.sof     <= sof;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        sb.take_rx_byte(b, sof);
        if (!ignored_traffic) counted_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        rx_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_station_address(input logic [7:0] addr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.station_address = addr;
        @(negedge i_clk);
    endtask

    function automatic void begin_frame(logic [7:0] addr, logic [7:0] fc);
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fc);
    endfunction

    function automatic void push_random_data(int n);
        repeat (n) frame_buf.push_back(8'($urandom));
    endfunction

    function automatic void close_frame(bit corrupt);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_buf[k]) crc = request_scoreboard::crc_step(crc, frame_buf[k]);
        if (corrupt) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endfunction

    function automatic logic [7:0] random_unknown_code();
        logic [7:0] fc;
        do fc = 8'($urandom);
        while ((fc >= FUNC_FIXED_LO && fc <= FUNC_FIXED_HI) || fc == FUNC_WRITE_MULT);
        return fc;
    endfunction

    task automatic send_frame(input bit start, input int count);
        int k;
        for (k = 0; k < count; k++) send_item(frame_buf[k], start && k == 0);
    endtask

    task automatic send_write_multiple(input int count, input bit corrupt, input bit start);
        begin_frame(sb.station_address, FUNC_WRITE_MULT);
        push_random_data(int'(LEN_BASE) - 1);
        frame_buf.push_back(8'(count));
        push_random_data(count);
        close_frame(corrupt);
        send_frame(start, frame_buf.size());
    endtask

    // one byte past a full store, either by an unknown code or by a too large count
    task automatic send_overflow(input bit by_count, input bit start);
        if (by_count) begin
            begin_frame(sb.station_address, FUNC_WRITE_MULT);
            push_random_data(int'(LEN_BASE) - 1);
            frame_buf.push_back(8'($urandom_range(MAX_COUNT + 1, 255)));
            push_random_data(MAX_COUNT + 1);
        end else begin
            begin_frame(sb.station_address, random_unknown_code());
            push_random_data(DATA_BYTES + 1);
        end
        send_frame(start, frame_buf.size());
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        bit start;
        pick  = $urandom_range(0, 99);
        start = ($urandom_range(0, 9) != 0);
        if (pick < 50) begin
            begin_frame(sb.station_address, 8'($urandom_range(FUNC_FIXED_LO, FUNC_FIXED_HI)));
            push_random_data(LEN_FIXED);
            close_frame(pick >= 42);
            send_frame(start, frame_buf.size());
        end else if (pick < 68) begin
            send_write_multiple(($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_COUNT)
                                                            : $urandom_range(0, 8),
                                pick >= 64, start);
        end else if (pick < 76) begin
            // cut short; a later start-marked byte throws it away
            begin_frame(sb.station_address, 8'($urandom_range(FUNC_FIXED_LO, FUNC_FIXED_HI)));
            push_random_data(LEN_FIXED);
            close_frame(1'b0);
            send_frame(start, $urandom_range(1, frame_buf.size() - 1));
        end else if (pick < 88) begin
            ignored_traffic = 1'b1;
            if (pick < 82) begin
                begin_frame(sb.station_address ^ 8'($urandom_range(1, 255)),
                            8'($urandom_range(FUNC_FIXED_LO, FUNC_FIXED_HI)));
                push_random_data(LEN_FIXED);
                close_frame(1'b0);
                send_frame(start, frame_buf.size());
            end else begin
                repeat ($urandom_range(1, 6)) send_item(8'($urandom), 1'($urandom));
            end
            ignored_traffic = 1'b0;
        end else if (pick < 95) begin
            // unknown code never reaches the crc, so this one stays open
            begin_frame(sb.station_address, random_unknown_code());
            push_random_data($urandom_range(0, 6));
            close_frame(1'b0);
            send_frame(start, frame_buf.size());
        end else if (pick < 97) begin
            send_overflow(pick[0], start);
        end else begin
            send_write_multiple(MAX_COUNT, $urandom_range(0, 3) == 0, start);
        end
    endtask

    initial begin
        logic [7:0] station_plan [5];
        int phase_end;
        int p;
        sb = new();
        i_rst_n       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 8'h00;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        rx_ch.sof     <= 1'b0;
        idling_on       = 1'b1;
        ignored_traffic = 1'b0;
        counted_items   = 0;
        station_plan = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)),
                         8'($urandom_range(2, 254)), 8'h01};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extreme data bytes, zero byte count, bad crc, unknown code
        begin_frame(sb.station_address, FUNC_FIXED_LO);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hFF);
        close_frame(1'b0);
        send_frame(1'b1, frame_buf.size());
        send_write_multiple(0, 1'b0, 1'b1);
        begin_frame(sb.station_address, FUNC_FIXED_HI);
        push_random_data(LEN_FIXED);
        close_frame(1'b1);
        send_frame(1'b1, frame_buf.size());
        begin_frame(sb.station_address, random_unknown_code());
        push_random_data(1);
        send_frame(1'b1, frame_buf.size());

        for (p = 0; p < 5; p++) begin
            wait_drain();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            write_station_address(station_plan[p]);
            idling_on = (p != 4);
            phase_end = counted_items + PHASE_ITEMS;
            case (p)
                0: send_overflow(1'b0, 1'b1);
                1: send_overflow(1'b1, 1'b1);
                2: send_write_multiple(MAX_COUNT, 1'b0, 1'b1);
                default: ;
            endcase
            while (counted_items < phase_end) begin
                send_random_frame();
                if ($urandom_range(0, 14) == 0) wait_drain();
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
